@@ sv/vspa_pkg.sv @@
package vspa_pkg;

  localparam int CmdW     = 2;
  localparam int TimeW    = 32;
  localparam int SpeedW   = 8;
  localparam int RpmW     = 16;
  localparam int StatusW  = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int DefRetryMs      = 150;
  localparam int DefAccelMaxGap  = 3000;
  localparam int MinAccelGap     = 500;
  localparam int AccelScale      = 100000;
  localparam int GapScale        = 36;
  localparam int RpmPerHundred   = 100;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_TAKE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_DROP  = 2'd2;
  localparam logic [CmdW-1:0] CMD_UNDEF = 2'd3;

  localparam logic [StatusW-1:0] ST_DISABLED = 4'd0;
  localparam logic [StatusW-1:0] ST_GATED    = 4'd1;
  localparam logic [StatusW-1:0] ST_NOT_DUE  = 4'd2;
  localparam logic [StatusW-1:0] ST_MISSED   = 4'd3;
  localparam logic [StatusW-1:0] ST_ABORTED  = 4'd4;
  localparam logic [StatusW-1:0] ST_NO_SPEED = 4'd5;
  localparam logic [StatusW-1:0] ST_OFF_HOLD = 4'd6;
  localparam logic [StatusW-1:0] ST_SAMPLED  = 4'd7;
  localparam logic [StatusW-1:0] ST_TAKEN    = 4'd8;
  localparam logic [StatusW-1:0] ST_DROPPED  = 4'd9;

  localparam logic [CfgIdxW-1:0] REG_PERIOD    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ACC_LIM   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BRK_LIM   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OVERSPEED = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_RPM  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MISS_LIM  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OFF_LIM   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_OFF_PROBE = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [TimeW-1:0]  now_ms;
    logic              link_valid;
    logic              poll_ok;
    logic              speed_present;
    logic [SpeedW-1:0] speed_kmh;
    logic              has_rpm;
    logic [RpmW-1:0]   engine_rpm;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [7:0]         sample_count;
    logic [7:0]         speed_min;
    logic [7:0]         speed_max;
    logic [7:0]         rpm_max_hundreds;
    logic signed [7:0]  accel_peak;
    logic signed [7:0]  decel_peak;
    logic [3:0]         event_flags;
    logic [7:0]         event_count;
    logic signed [7:0]  sample_accel;
  } out_item_t;

  // Work handed from the pacer to the accumulator.
  typedef enum logic [1:0] {
    JOB_REPORT = 2'd0,  // emit status with current aggregate
    JOB_TAKE   = 2'd1,
    JOB_DROP   = 2'd2,
    JOB_SAMPLE = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [StatusW-1:0] status;
    logic [SpeedW-1:0]  speed;
    logic               has_rpm;
    logic [RpmW-1:0]    rpm;
    logic               accel_ok;   // gap in range, compute acceleration
    logic signed [8:0]  dspeed;
    logic [15:0]        gap_ms;
  } job_t;

  typedef struct packed {
    logic signed [7:0] acc_lim;
    logic signed [7:0] brk_lim;
    logic [7:0]        overspeed;
    logic [15:0]       idle_rpm;
  } evt_cfg_t;

endpackage

@@ sv/vspa_if.sv @@
interface vspa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/vspa_fifo.sv @@
module vspa_fifo
  import vspa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ sv/vspa_pacer.sv @@
module vspa_pacer
  import vspa_pkg::*;
#(
  parameter int RETRY_MS         = DefRetryMs,
  parameter int ACCEL_MAX_GAP_MS = DefAccelMaxGap
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  input  logic [15:0]       period,
  input  logic [7:0]        miss_lim,
  input  logic [7:0]        off_lim,
  input  logic [15:0]       off_probe,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_data
);
  logic [TimeW-1:0] next_r, prev_time_r;
  logic             started_r, abort_r, last_link_r, hold_r, have_prev_r;
  logic [7:0]       miss_r, off_r, prev_spd_r;

  function automatic logic is_before(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return d[TimeW-1];
  endfunction

  logic [TimeW-1:0] now, grid0, grid1, next_v, retry_t;
  logic             rise, abort_in, abort_v, hold_v, fire, off_sample;
  logic [7:0]       miss_v, off_v;
  logic [TimeW-1:0] dt;
  job_t             job;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign now = in_data.now_ms;
  assign rise = in_data.link_valid && !last_link_r;
  assign abort_in = rise ? 1'b0 : abort_r;
  assign retry_t = now + TimeW'(RETRY_MS);
  assign dt = now - prev_time_r;

  always_comb begin
    job = '0;
    job.kind = JOB_REPORT;
    job.speed = in_data.speed_kmh;
    job.has_rpm = in_data.has_rpm;
    job.rpm = in_data.has_rpm ? in_data.engine_rpm : '0;
    job.dspeed = $signed({1'b0, in_data.speed_kmh}) - $signed({1'b0, prev_spd_r});
    job.gap_ms = dt[15:0];
    job.accel_ok = have_prev_r && dt >= TimeW'(MinAccelGap) && dt <= TimeW'(ACCEL_MAX_GAP_MS);
    abort_v = abort_in;
    hold_v = rise ? 1'b0 : hold_r;
    miss_v = rise ? 8'd0 : miss_r;
    off_v = rise ? 8'd0 : off_r;
    grid0 = started_r ? next_r : now;
    next_v = grid0;
    grid1 = grid0 + TimeW'(period);
    off_sample = in_data.has_rpm && in_data.engine_rpm == '0 && in_data.speed_kmh == '0;
    if (in_data.command == CMD_TAKE) begin
      job.kind = JOB_TAKE;
      job.status = ST_TAKEN;
    end else if (in_data.command == CMD_DROP) begin
      job.kind = JOB_DROP;
      job.status = ST_DROPPED;
    end else if (period == '0) begin
      job.status = ST_DISABLED;
    end else if (!in_data.link_valid) begin
      job.status = ST_GATED;
    end else if (abort_v) begin
      job.status = ST_ABORTED;
    end else if (is_before(now, grid0)) begin
      job.status = ST_NOT_DUE;
    end else begin
      next_v = is_before(now, grid1) ? grid1 : now + TimeW'(period);
      if (!in_data.poll_ok) begin
        if (miss_v != 8'd255) miss_v = miss_v + 8'd1;
        if (miss_v >= miss_lim) begin
          abort_v = 1'b1;
          job.status = ST_ABORTED;
        end else begin
          if (!hold_v && is_before(retry_t, next_v)) next_v = retry_t;
          job.status = ST_MISSED;
        end
      end else begin
        miss_v = 8'd0;
        if (!in_data.speed_present) begin
          if (!hold_v && is_before(retry_t, next_v)) next_v = retry_t;
          job.status = ST_NO_SPEED;
        end else begin
          if (off_sample) begin
            if (off_v < off_lim) off_v = off_v + 8'd1;
            if (off_v >= off_lim) hold_v = 1'b1;
          end else begin
            off_v = 8'd0;
            hold_v = 1'b0;
          end
          if (hold_v) begin
            next_v = now + TimeW'(off_probe);
            job.status = ST_OFF_HOLD;
          end else begin
            job.kind = JOB_SAMPLE;
            job.status = ST_SAMPLED;
          end
        end
      end
    end
  end

  assign q_push = fire;
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r <= '0; prev_time_r <= '0; started_r <= 1'b0; abort_r <= 1'b0;
      last_link_r <= 1'b0; hold_r <= 1'b0; have_prev_r <= 1'b0;
      miss_r <= '0; off_r <= '0; prev_spd_r <= '0;
    end else if (fire && in_data.command != CMD_TAKE && in_data.command != CMD_DROP
                 && period != '0) begin
      last_link_r <= in_data.link_valid;
      abort_r <= abort_v;
      hold_r <= hold_v;
      miss_r <= miss_v;
      off_r <= off_v;
      // The grid advances for every tick that passes the gates, including the
      // missed poll that latches the abort.
      if (in_data.link_valid && !abort_in) begin
        started_r <= 1'b1;
        next_r <= next_v;
      end
      if (job.kind == JOB_SAMPLE) begin
        have_prev_r <= 1'b1;
        prev_spd_r <= in_data.speed_kmh;
        prev_time_r <= now;
      end
    end
  end
endmodule

@@ sv/vspa_accum.sv @@
module vspa_accum
  import vspa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  job_t     q_data,
  output logic     q_pop,
  input  evt_cfg_t ecfg,
  output logic     out_valid,
  input  logic     out_ready,
  output out_item_t out_data
);
  // Serial restoring divider: |dspeed|*100000 (25 bits) / (36*gap) (up to 22 bits).
  localparam int NumW = 25;
  localparam int DenW = 22;
  localparam int CntW = $clog2(NumW + 1);
  // rpm / 100 as a multiply by 5243 and a shift by 19, exact over the unsaturated range below 25500.
  localparam int RecipHundred = 5243;
  localparam int RecipShift   = 19;

  typedef enum logic [2:0] {S_IDLE, S_DENOM, S_DIV, S_FIN, S_OUT} state_t;
  state_t state_r;

  job_t             job_r;
  logic [NumW-1:0]  num_r;
  logic [DenW-1:0]  den_r;
  logic [NumW-1:0]  rem_r;
  logic [CntW-1:0]  cnt_r;
  logic             neg_r;

  logic       any_r;
  logic [7:0] cnt_agg_r, smin_r, smax_r, rpm_r, ecnt_r;
  logic signed [7:0] amax_r, dmin_r;
  logic [3:0] ev_r, act_r;
  out_item_t  out_r;
  logic       ov_r;

  logic [NumW:0]   rem_sh;
  logic [NumW-1:0] q_sat;
  logic signed [7:0] accel;
  logic [28:0] hund_prod;
  logic [7:0] hund;
  logic [3:0] act, rising;
  logic [7:0] ecnt_v;
  logic [8:0] dabs;
  logic       res_load;

  assign dabs = q_data.dspeed[8] ? 9'(-q_data.dspeed) : 9'(q_data.dspeed);
  assign rem_sh = {rem_r, num_r[NumW-1]};
  assign q_pop = state_r == S_IDLE && !q_empty;
  assign out_valid = ov_r;
  assign out_data = out_r;
  assign res_load = (state_r == S_FIN || state_r == S_OUT) && (!ov_r || out_ready);

  always_comb begin
    hund_prod = 29'(job_r.rpm) * 29'(RecipHundred);
    hund = (job_r.rpm >= 16'(255 * RpmPerHundred)) ? 8'd255
         : 8'(hund_prod >> RecipShift);
    q_sat = num_r;
    if (!job_r.accel_ok) accel = '0;
    else if (neg_r) accel = (q_sat > NumW'(128)) ? -8'sd128 : 8'(-$signed({1'b0, q_sat}));
    else accel = (q_sat > NumW'(127)) ? 8'sd127 : 8'(q_sat);
    act = '0;
    act[0] = accel >= ecfg.acc_lim;
    act[1] = accel <= ecfg.brk_lim;
    act[2] = job_r.speed >= ecfg.overspeed;
    act[3] = job_r.speed == '0 && job_r.has_rpm && job_r.rpm > ecfg.idle_rpm;
    rising = act & ~act_r;
    ecnt_v = ecnt_r;
    for (int b = 0; b < 4; b++) begin
      if (rising[b] && ecnt_v != 8'd255) ecnt_v = ecnt_v + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; any_r <= 1'b0;
      cnt_agg_r <= '0; smin_r <= '0; smax_r <= '0; rpm_r <= '0; ecnt_r <= '0;
      amax_r <= '0; dmin_r <= '0; ev_r <= '0; act_r <= '0;
    end else begin
      if (res_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r <= q_data;
            num_r <= NumW'(dabs) * NumW'(AccelScale);
            neg_r <= q_data.dspeed[8];
            state_r <= (q_data.kind == JOB_SAMPLE) ? S_DENOM : S_OUT;
          end
        end
        S_DENOM: begin
          den_r <= DenW'(job_r.gap_ms) * DenW'(GapScale);
          rem_r <= '0;
          cnt_r <= CntW'(NumW);
          state_r <= job_r.accel_ok ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (rem_sh >= {{(NumW + 1 - DenW){1'b0}}, den_r}) begin
            rem_r <= NumW'(rem_sh - {{(NumW + 1 - DenW){1'b0}}, den_r});
            num_r <= {num_r[NumW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[NumW-1:0];
            num_r <= {num_r[NumW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CntW'(1);
          if (cnt_r == CntW'(1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!ov_r || out_ready) begin
            if (!any_r) begin
              smin_r <= job_r.speed; smax_r <= job_r.speed; any_r <= 1'b1;
            end else begin
              if (job_r.speed > smax_r) smax_r <= job_r.speed;
              if (job_r.speed < smin_r) smin_r <= job_r.speed;
            end
            if (job_r.has_rpm && hund > rpm_r) rpm_r <= hund;
            if (cnt_agg_r != 8'd255) cnt_agg_r <= cnt_agg_r + 8'd1;
            if (accel > amax_r) amax_r <= accel;
            if (accel < dmin_r) dmin_r <= accel;
            ev_r <= ev_r | rising;
            ecnt_r <= ecnt_v;
            act_r <= act;
            out_r.status <= ST_SAMPLED;
            out_r.sample_count <= (cnt_agg_r != 8'd255) ? cnt_agg_r + 8'd1 : cnt_agg_r;
            out_r.speed_min <= (!any_r || job_r.speed < smin_r) ? job_r.speed : smin_r;
            out_r.speed_max <= (!any_r || job_r.speed > smax_r) ? job_r.speed : smax_r;
            out_r.rpm_max_hundreds <= (job_r.has_rpm && hund > rpm_r) ? hund : rpm_r;
            out_r.accel_peak <= (accel > amax_r) ? accel : amax_r;
            out_r.decel_peak <= (accel < dmin_r) ? accel : dmin_r;
            out_r.event_flags <= ev_r | rising;
            out_r.event_count <= ecnt_v;
            out_r.sample_accel <= accel;
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!ov_r || out_ready) begin
            // A drop reports the aggregate after clearing, so all zero.
            out_r.status <= job_r.status;
            out_r.sample_count <= (job_r.kind == JOB_DROP) ? '0 : cnt_agg_r;
            out_r.speed_min <= (job_r.kind == JOB_DROP) ? '0 : smin_r;
            out_r.speed_max <= (job_r.kind == JOB_DROP) ? '0 : smax_r;
            out_r.rpm_max_hundreds <= (job_r.kind == JOB_DROP) ? '0 : rpm_r;
            out_r.accel_peak <= (job_r.kind == JOB_DROP) ? '0 : amax_r;
            out_r.decel_peak <= (job_r.kind == JOB_DROP) ? '0 : dmin_r;
            out_r.event_flags <= (job_r.kind == JOB_DROP) ? '0 : ev_r;
            out_r.event_count <= (job_r.kind == JOB_DROP) ? '0 : ecnt_r;
            out_r.sample_accel <= '0;
            if (job_r.kind == JOB_TAKE || job_r.kind == JOB_DROP) begin
              any_r <= 1'b0; cnt_agg_r <= '0; smin_r <= '0; smax_r <= '0;
              rpm_r <= '0; amax_r <= '0; dmin_r <= '0; ev_r <= '0;
              ecnt_r <= '0; act_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/vehicle_sample_pacer_aggregator.sv @@
// Channel | Direction | Payload
// in_     | sink      | command, now_ms, link_valid, poll_ok, speed_present, speed_kmh,
//         |           | has_rpm, engine_rpm
// out_    | source    | status, aggregate fields, sample_accel
// cfg_    | write     | index 0..7, 16-bit data
//
// The pacer classifies a transfer in the cycle it is accepted and pushes a job into
// a two-entry queue. The accumulator turns a report, take or drop job into a result via
// S_IDLE and S_OUT; a sample job passes S_IDLE, S_DENOM, the 25-step serial divider
// that computes the acceleration when the gap is in range, else skipped, and S_FIN.
// Reset is synchronous and clears all control and aggregate state. A stalled result
// holds in the output register while the pacer keeps accepting until the queue fills.
module vehicle_sample_pacer_aggregator
  import vspa_pkg::*;
#(
  parameter int RETRY_MS         = DefRetryMs,
  parameter int ACCEL_MAX_GAP_MS = DefAccelMaxGap
) (
  input  logic                clk,
  input  logic                rst_n,
  vspa_if.sink                in_ch,
  vspa_if.source              out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  logic [15:0] period_r, idle_rpm_r, off_probe_r;
  logic [7:0]  acc_lim_r, brk_lim_r, overspeed_r, miss_lim_r, off_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1000;
      acc_lim_r <= 8'd30;
      brk_lim_r <= 8'hE2;
      overspeed_r <= 8'd120;
      idle_rpm_r <= 16'd500;
      miss_lim_r <= 8'd5;
      off_lim_r <= 8'd10;
      off_probe_r <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:    period_r <= cfg_data;
        REG_ACC_LIM:   acc_lim_r <= cfg_data[7:0];
        REG_BRK_LIM:   brk_lim_r <= cfg_data[7:0];
        REG_OVERSPEED: overspeed_r <= cfg_data[7:0];
        REG_IDLE_RPM:  idle_rpm_r <= cfg_data;
        REG_MISS_LIM:  miss_lim_r <= cfg_data[7:0];
        REG_OFF_LIM:   off_lim_r <= cfg_data[7:0];
        REG_OFF_PROBE: off_probe_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic     q_full, q_push, q_pop, q_empty;
  job_t     q_in, q_out;
  evt_cfg_t ecfg;

  assign ecfg = '{acc_lim: acc_lim_r, brk_lim: brk_lim_r,
                  overspeed: overspeed_r, idle_rpm: idle_rpm_r};

  vspa_pacer #(.RETRY_MS(RETRY_MS), .ACCEL_MAX_GAP_MS(ACCEL_MAX_GAP_MS)) u_pacer (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .period(period_r), .miss_lim(miss_lim_r), .off_lim(off_lim_r),
    .off_probe(off_probe_r),
    .q_full, .q_push, .q_data(q_in)
  );

  vspa_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  vspa_accum u_accum (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop, .ecfg,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  // The queue never overflows or underflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_push)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_empty && q_pop)) else $error("queue underflow");
  // A drop result always reports an empty aggregate.
  a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status == ST_DROPPED) |-> out_ch.data.sample_count == '0)
    else $error("drop result not cleared");
endmodule
